>>> design/srsm_pkg.sv
// Shared constants, codes and types of the strided range set membership block.
`default_nettype none
package srsm_pkg;

	localparam int TBL_DEPTH = 64;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int STEP_W    = DATA_W - 1;
	localparam int REM_CNT_W = $clog2(DATA_W);
	localparam int APB_AW    = 3;

	// Register index bit within paddr.
	localparam int REG_IDX_BIT = 2;
	localparam logic REG_LOW_LIMIT  = 1'b0;
	localparam logic REG_HIGH_LIMIT = 1'b1;

	localparam logic signed [DATA_W-1:0] LOW_LIMIT_RST  = 32'sh0000_0000;
	localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 32'sh7fff_ffff;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_ORDER   = 3'd1,
		STAT_LOW     = 3'd2,
		STAT_HIGH    = 3'd3,
		STAT_OVERLAP = 3'd4,
		STAT_STEP    = 3'd5,
		STAT_FULL    = 3'd6
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;
		logic [STEP_W-1:0]        step;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [STEP_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic              done;
		logic [STEP_W-1:0] rem;
	} rem_rsp_t;

endpackage
`default_nettype wire

>>> design/srsm_ifs.sv
// Request and response channel interfaces of the strided range set membership block.
`default_nettype none
interface srsm_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             func;
	logic signed [srsm_pkg::DATA_W-1:0]     entry_lower;
	logic signed [srsm_pkg::DATA_W-1:0]     entry_upper;
	logic signed [srsm_pkg::DATA_W-1:0]     entry_step;
	logic signed [srsm_pkg::DATA_W-1:0]     query_value;

	modport source (output valid, func, entry_lower, entry_upper, entry_step, query_value,
		input ready);
	modport sink (input valid, func, entry_lower, entry_upper, entry_step, query_value,
		output ready);
endinterface

interface srsm_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           is_member;
	logic [2:0]                     status;
	logic [srsm_pkg::CNT_W-1:0]     entry_count;

	modport source (output valid, is_member, status, entry_count, input ready);
	modport sink (input valid, is_member, status, entry_count, output ready);
endinterface
`default_nettype wire

>>> design/srsm_rem.sv
// Bit-serial remainder unit: one restoring step per cycle over a 32-bit dividend.
`default_nettype none
module srsm_rem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srsm_pkg::rem_req_t req,
	output srsm_pkg::rem_rsp_t      rsp
);
	import srsm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    dvd_q;
	logic [STEP_W-1:0]    dvs_q;
	logic [STEP_W-1:0]    rem_q;

	logic [DATA_W-1:0] trial;
	logic [DATA_W-1:0] sub;
	logic              fits;

	always_comb begin
		trial = {rem_q, dvd_q[DATA_W-1]};
		sub   = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == REM_CNT_W'(DATA_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + REM_CNT_W'(1);
				if (cnt_q == REM_CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= fits ? sub[STEP_W-1:0] : trial[STEP_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

>>> design/srsm_table.sv
// Sub-range table: one write port and one registered read port.
`default_nettype none
module srsm_table (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [srsm_pkg::ADDR_W-1:0] wr_addr,
	input  wire srsm_pkg::entry_t            wr_data,
	input  wire logic                        rd_en,
	input  wire logic [srsm_pkg::ADDR_W-1:0] rd_addr,
	output srsm_pkg::entry_t                 rd_data
);
	import srsm_pkg::*;

	entry_t mem_q [TBL_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> design/strided_range_set_membership.sv
// Flow: clear and unused items go from accept straight to the done state; append runs
// the checks, then 32 serial remainder steps; query checks the first lower bound, runs
// a binary search (a read and a compare per probe, 6 probes for 64 entries), then the remainder.
// Throughput: one item at a time; the next item is taken as soon as the result is
// registered, even while that result beat still waits on the sink.
// Reset clears the count and the last element and returns the limits to 0 and 2147483647.
`default_nettype none
module strided_range_set_membership (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	srsm_req_if.sink                         req,
	srsm_rsp_if.source                       rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [srsm_pkg::APB_AW-1:0] paddr,
	input  wire logic [srsm_pkg::DATA_W-1:0] pwdata,
	output logic [srsm_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import srsm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACHK,
		ST_ADIV,
		ST_QLO,
		ST_QSRCH,
		ST_QCMP,
		ST_QFET,
		ST_QDIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [DATA_W-1:0] low_limit_q;
	logic signed [DATA_W-1:0] high_limit_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] up_q;
	logic signed [DATA_W-1:0] st_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] last_q;
	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        l_q;
	logic [ADDR_W-1:0]        r_q;
	logic [ADDR_W-1:0]        m_q;
	logic                     member_q;
	status_t                  status_q;
	logic                     rsp_valid_q;
	logic                     rsp_member_q;
	logic [2:0]               rsp_status_q;
	logic [CNT_W-1:0]         rsp_count_q;

	logic              tbl_wr;
	logic              tbl_rd;
	logic [ADDR_W-1:0] tbl_raddr;
	entry_t            tbl_wdata;
	entry_t            tbl_rdata;
	rem_req_t          rem_req;
	rem_rsp_t          rem_rsp;
	status_t           app_status;
	logic [ADDR_W:0]   m_sum;
	logic [ADDR_W-1:0] m_next;
	logic              cfg_wr;

	// Configuration registers.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RST;
			high_limit_q <= HIGH_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[REG_IDX_BIT])
				REG_LOW_LIMIT:  low_limit_q  <= pwdata;
				REG_HIGH_LIMIT: high_limit_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_IDX_BIT])
			REG_LOW_LIMIT:  prdata = low_limit_q;
			REG_HIGH_LIMIT: prdata = high_limit_q;
			default:        prdata = '0;
		endcase
	end

	// Append checks, first failing check wins.
	always_comb begin
		if (count_q >= CNT_W'(TBL_DEPTH))
			app_status = STAT_FULL;
		else if (st_q < 32'sd1)
			app_status = STAT_STEP;
		else if (lo_q > up_q)
			app_status = STAT_ORDER;
		else if (lo_q < low_limit_q)
			app_status = STAT_LOW;
		else if (up_q >= high_limit_q)
			app_status = STAT_HIGH;
		else if (count_q != '0 && last_q >= lo_q)
			app_status = STAT_OVERLAP;
		else
			app_status = STAT_OK;
	end

	always_comb begin
		m_sum  = (ADDR_W+1)'(l_q) + (ADDR_W+1)'(r_q) + (ADDR_W+1)'(1);
		m_next = m_sum[ADDR_W:1];
	end

	// Table and remainder unit control.
	always_comb begin
		tbl_wr          = 1'b0;
		tbl_rd          = 1'b0;
		tbl_raddr       = l_q;
		tbl_wdata.lower = lo_q;
		tbl_wdata.upper = up_q;
		tbl_wdata.step  = st_q[STEP_W-1:0];
		rem_req.start    = 1'b0;
		rem_req.dividend = DATA_W'(up_q - lo_q);
		rem_req.divisor  = st_q[STEP_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && func_t'(req.func) == FUNC_QUERY && count_q != '0) begin
					tbl_rd    = 1'b1;
					tbl_raddr = '0;
				end
			end
			ST_ACHK: begin
				if (app_status == STAT_OK) begin
					tbl_wr        = 1'b1;
					rem_req.start = 1'b1;
				end
			end
			ST_QSRCH: begin
				tbl_rd    = 1'b1;
				tbl_raddr = (l_q < r_q) ? m_next : l_q;
			end
			ST_QFET: begin
				rem_req.dividend = DATA_W'(val_q - tbl_rdata.lower);
				rem_req.divisor  = tbl_rdata.step;
				rem_req.start    = (val_q <= tbl_rdata.upper);
			end
			default: ;
		endcase
	end

	srsm_table u_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (tbl_wdata),
		.rd_en   (tbl_rd),
		.rd_addr (tbl_raddr),
		.rd_data (tbl_rdata)
	);

	srsm_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			last_q       <= '0;
			member_q     <= 1'b0;
			status_q     <= STAT_OK;
			rsp_valid_q  <= 1'b0;
			rsp_member_q <= 1'b0;
			rsp_status_q <= '0;
			rsp_count_q  <= '0;
		end else begin
			// the done state owns the result register while it is active
			if (rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						member_q <= 1'b0;
						status_q <= STAT_OK;
						unique case (func_t'(req.func))
							FUNC_CLEAR: begin
								count_q <= '0;
								last_q  <= '0;
								state_q <= ST_DONE;
							end
							FUNC_APPEND: state_q <= ST_ACHK;
							FUNC_QUERY:  state_q <= (count_q != '0) ? ST_QLO : ST_DONE;
							default:     state_q <= ST_DONE;
						endcase
					end
				end
				ST_ACHK: begin
					status_q <= app_status;
					if (app_status == STAT_OK) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_ADIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ADIV: begin
					if (rem_rsp.done) begin
						// last element = lower + diff - diff mod step = upper - remainder
						last_q  <= up_q - DATA_W'({1'b0, rem_rsp.rem});
						state_q <= ST_DONE;
					end
				end
				ST_QLO: begin
					if (val_q < tbl_rdata.lower || val_q > last_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_QSRCH;
					end
				end
				ST_QSRCH: begin
					state_q <= (l_q < r_q) ? ST_QCMP : ST_QFET;
				end
				ST_QCMP: begin
					state_q <= ST_QSRCH;
				end
				ST_QFET: begin
					state_q <= (val_q <= tbl_rdata.upper) ? ST_QDIV : ST_DONE;
				end
				ST_QDIV: begin
					if (rem_rsp.done) begin
						member_q <= (rem_rsp.rem == '0);
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_member_q <= member_q;
						rsp_status_q <= status_q;
						rsp_count_q  <= count_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and search bounds.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			lo_q  <= req.entry_lower;
			up_q  <= req.entry_upper;
			st_q  <= req.entry_step;
			val_q <= req.query_value;
		end
		if (state_q == ST_QLO) begin
			l_q <= '0;
			r_q <= ADDR_W'(count_q - CNT_W'(1));
		end
		if (state_q == ST_QSRCH) begin
			m_q <= m_next;
		end
		if (state_q == ST_QCMP) begin
			if (val_q < tbl_rdata.lower) begin
				r_q <= m_q - ADDR_W'(1);
			end else begin
				l_q <= m_q;
			end
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.is_member   = rsp_member_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TBL_DEPTH))
		else $error("entry count above table depth");

	a_rem_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (state_q == ST_ADIV || state_q == ST_QDIV))
		else $error("remainder finished outside a waiting state");

	a_write_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("table write without count advance");

	a_beat_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside done state");

endmodule
`default_nettype wire

>>> dv/srsm_result_check.sv
// Watches the request, result and register ports, predicts every result beat and compares it.
`timescale 1ns / 100ps
module srsm_result_check (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	srsm_req_if                              req,
	srsm_rsp_if                              rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [srsm_pkg::APB_AW-1:0] paddr,
	input  wire logic [srsm_pkg::DATA_W-1:0] pwdata,
	input  wire logic [srsm_pkg::DATA_W-1:0] prdata,
	input  wire logic                        pready,
	output int                               fails,
	output int                               owed,
	output int                               beats
);
	import srsm_pkg::*;

	typedef struct packed {
		logic             is_member;
		status_t          status;
		logic [CNT_W-1:0] count;
	} outcome_t;

	outcome_t owed_results[$];

	longint low_lim = 0;
	longint high_lim = 64'sh7FFF_FFFF;
	longint tbl_lo[TBL_DEPTH];
	longint tbl_up[TBL_DEPTH];
	longint tbl_step[TBL_DEPTH];
	int     held = 0;
	longint tail_elem = 0;

	int err_total = 0;
	int owed_n = 0;
	int beat_total = 0;

	assign fails = err_total;
	assign owed  = owed_n;
	assign beats = beat_total;

	task automatic note_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		err_total++;
	endtask

	function automatic status_t try_append(input longint lo, input longint up, input longint st);
		longint span;
		if (held >= TBL_DEPTH) return STAT_FULL;
		if (st < 1) return STAT_STEP;
		if (lo > up) return STAT_ORDER;
		if (lo < low_lim) return STAT_LOW;
		if (up >= high_lim) return STAT_HIGH;
		if (held > 0 && tail_elem >= lo) return STAT_OVERLAP;
		tbl_lo[held] = lo;
		tbl_up[held] = up;
		tbl_step[held] = st;
		held++;
		// last element is the highest lower + k*step that does not pass upper
		span = up - lo;
		tail_elem = lo + (span - span % st);
		return STAT_OK;
	endfunction

	function automatic logic lookup(input longint v);
		int l, r, m;
		if (held == 0) return 1'b0;
		if (v < tbl_lo[0] || v > tail_elem) return 1'b0;
		l = 0;
		r = held - 1;
		// find the last sub-range whose lower is at most v
		while (l < r) begin
			m = (l + r + 1) / 2;
			if (v < tbl_lo[m]) r = m - 1;
			else l = m;
		end
		if (v > tbl_up[l]) return 1'b0;
		return ((v - tbl_lo[l]) % tbl_step[l]) == 0;
	endfunction

	function automatic outcome_t membership_outcome(input func_t f, input longint lo,
			input longint up, input longint st, input longint qv);
		outcome_t o;
		o.is_member = 1'b0;
		o.status = STAT_OK;
		case (f)
		FUNC_CLEAR: begin
			held = 0;
			tail_elem = 0;
		end
		FUNC_APPEND: o.status = try_append(lo, up, st);
		FUNC_QUERY: o.is_member = lookup(qv);
		default: ;
		endcase
		o.count = CNT_W'(held);
		return o;
	endfunction

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				owed_results.push_back(membership_outcome(func_t'(req.func),
					longint'($signed(req.entry_lower)), longint'($signed(req.entry_upper)),
					longint'($signed(req.entry_step)), longint'($signed(req.query_value))));

			if (rsp.valid && rsp.ready) begin
				beat_total++;
				if (owed_results.size() == 0) begin
					note_error("result beat with no item outstanding");
				end else begin
					want = owed_results.pop_front();
					if (rsp.is_member !== want.is_member)
						note_error($sformatf("is_member %b, expected %b",
							rsp.is_member, want.is_member));
					if (rsp.status !== want.status)
						note_error($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.entry_count !== want.count)
						note_error($sformatf("entry_count %0d, expected %0d",
							rsp.entry_count, want.count));
				end
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[REG_IDX_BIT] == REG_HIGH_LIMIT)
						high_lim = longint'($signed(pwdata));
					else
						low_lim = longint'($signed(pwdata));
				end else if (paddr[REG_IDX_BIT] == REG_HIGH_LIMIT) begin
					if (prdata !== DATA_W'(high_lim))
						note_error($sformatf("high_limit read %h, expected %h",
							prdata, DATA_W'(high_lim)));
				end else if (prdata !== DATA_W'(low_lim)) begin
					note_error($sformatf("low_limit read %h, expected %h",
						prdata, DATA_W'(low_lim)));
				end
			end

			owed_n <= owed_results.size();
		end
	end

endmodule

>>> dv/testbench.sv
// Top of the testbench: clock, reset, request and register stimulus, result stalls and verdict.
`timescale 1ns / 100ps
module testbench;
	import srsm_pkg::*;

	localparam longint S32_MIN = 64'shFFFF_FFFF_8000_0000;
	localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	srsm_req_if req_ch();
	srsm_rsp_if rsp_ch();

	int fails, owed, beats;
	bit calm = 1'b0;
	int items_sent = 0;
	int builds = 0;
	int settings = 0;

	// limits in force and the table this side has built, used to aim the stimulus
	longint lim_lo = 0;
	longint lim_hi = S32_MAX;
	longint built_lo[TBL_DEPTH];
	longint built_up[TBL_DEPTH];
	longint built_step[TBL_DEPTH];
	longint built_last[TBL_DEPTH];
	int     built_n = 0;
	longint built_tail = 0;

	strided_range_set_membership dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	srsm_result_check mcheck (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fails   (fails),
		.owed    (owed),
		.beats   (beats)
	);

	always #5 clk = ~clk;

	always @(posedge clk) rsp_ch.ready <= calm || ($urandom_range(99) >= 33);

	function automatic longint rand_upto(input longint cap);
		if (cap <= 0) return 0;
		if (cap > 64'sh0000_0000_FFFF_FFFF) cap = 64'sh0000_0000_FFFF_FFFF;
		return longint'($urandom_range(32'(cap)));
	endfunction

	task automatic send_item(input func_t f, input logic [31:0] lo, input logic [31:0] up,
			input logic [31:0] st, input logic [31:0] qv);
		int gap;
		if (!calm && $urandom_range(99) < 33) begin
			gap = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.entry_lower <= lo;
		req_ch.entry_upper <= up;
		req_ch.entry_step <= st;
		req_ch.query_value <= qv;
		// hold the beat until the block takes it
		do @(posedge clk); while (!req_ch.ready);
		if (f != FUNC_NONE) items_sent++;
	endtask

	task automatic send_clear();
		send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
		built_n = 0;
		built_tail = 0;
	endtask

	task automatic send_append(input longint lo, input longint up, input longint st);
		send_item(FUNC_APPEND, 32'(lo), 32'(up), 32'(st), $urandom);
	endtask

	task automatic send_query(input longint v);
		send_item(FUNC_QUERY, $urandom, $urandom, $urandom, 32'(v));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx, input logic [DATA_W-1:0] data);
		logic [APB_AW-1:0] a;
		a = '0;
		a[REG_IDX_BIT] = idx;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_limits(input longint lo, input longint hi);
		settle();
		apb_access(1'b1, REG_LOW_LIMIT, DATA_W'(lo));
		apb_access(1'b1, REG_HIGH_LIMIT, DATA_W'(hi));
		apb_access(1'b0, REG_LOW_LIMIT, '0);
		apb_access(1'b0, REG_HIGH_LIMIT, '0);
		psel <= 1'b0;
		penable <= 1'b0;
		lim_lo = lo;
		lim_hi = hi;
		settings++;
	endtask

	task automatic pick_limits();
		longint a, b, t;
		case ($urandom_range(9))
		0: begin a = 0; b = S32_MAX; end
		1: begin a = S32_MIN; b = S32_MAX; end
		2: begin a = -1000; b = 1000; end
		3: begin a = 5; b = 6; end
		4: begin a = S32_MAX; b = S32_MIN; end
		5: begin a = S32_MIN; b = S32_MIN; end
		8: begin a = -50; b = S32_MAX; end
		9: begin a = S32_MIN; b = 0; end
		default: begin
			a = longint'($signed($urandom));
			b = longint'($signed($urandom));
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
		end
		endcase
		set_limits(a, b);
	endtask

	function automatic longint pick_query();
		longint v;
		int j;
		if (built_n == 0) return ($urandom_range(1) == 0) ? lim_lo : longint'($signed($urandom));
		j = $urandom_range(built_n - 1);
		case ($urandom_range(9))
		0: v = built_lo[j];
		1: v = built_last[j];
		2: v = built_lo[j] + built_step[j] *
			rand_upto((built_last[j] - built_lo[j]) / built_step[j]);
		3: v = built_lo[j] + built_step[j] *
			rand_upto((built_last[j] - built_lo[j]) / built_step[j]) + 1;
		4: v = built_up[j];
		5: v = built_up[j] + 1;
		6: v = built_lo[j] - 1;
		7: v = longint'($signed($urandom));
		8: v = built_tail + 1;
		default: v = built_lo[0] - 1;
		endcase
		if (v < S32_MIN || v > S32_MAX) v = longint'($signed($urandom));
		return v;
	endfunction

	// Append a sub-range above the tail, under the limits; with no room, a failing one.
	task automatic build_append();
		longint start, room, st, span;
		if (built_n == 0) begin
			case ($urandom_range(3))
			0: start = lim_lo;
			1: start = lim_lo + rand_upto(lim_hi - 1 - lim_lo);
			default: start = lim_lo + rand_upto(20);
			endcase
		end else begin
			case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: start = built_tail + 1 + rand_upto(20);
			6, 7, 8: start = built_tail + 1 + rand_upto(1000);
			default: start = built_tail + 1 + rand_upto((lim_hi - 1 - built_tail) / 4);
			endcase
		end
		if (start > lim_hi - 1) begin
			// no room under the limits: this one lands on the full, limit or overlap check
			send_append(lim_lo, lim_lo, 1);
			return;
		end
		room = lim_hi - 1 - start;
		case ($urandom_range(9))
		0, 1, 2, 3, 4: st = 1 + rand_upto(3);
		5, 6, 7: st = 5 + rand_upto(95);
		default: st = 1 + rand_upto(64'sh7FFF_FFFE);
		endcase
		case ($urandom_range(9))
		0, 1, 2, 3: span = st * rand_upto(10) + rand_upto(st - 1);
		4, 5, 6: span = rand_upto(50);
		7, 8: span = rand_upto(room);
		default: span = 0;
		endcase
		if (span > room) span = room;
		send_append(start, start + span, st);
		if (built_n < TBL_DEPTH) begin
			built_lo[built_n] = start;
			built_up[built_n] = start + span;
			built_step[built_n] = st;
			built_last[built_n] = start + (span - span % st);
			built_tail = built_last[built_n];
			built_n++;
		end
	endtask

	// Items that break one of the append checks, plus idle selectors, stray clears and queries.
	task automatic send_noise();
		longint lo, up;
		case ($urandom_range(7))
		0: send_item(FUNC_APPEND, $urandom, $urandom, $urandom | 32'h8000_0000, $urandom);
		1: send_item(FUNC_APPEND, $urandom, $urandom, '0, $urandom);
		2: begin
			lo = S32_MIN + 1 + rand_upto(S32_MAX - S32_MIN - 1);
			up = lo - 1 - rand_upto(lo - 1 - S32_MIN);
			send_append(lo, up, 1 + rand_upto(99));
		end
		3: begin
			if (lim_lo > S32_MIN) begin
				lo = lim_lo - 1 - rand_upto(lim_lo - 1 - S32_MIN);
				up = lo + rand_upto(S32_MAX - lo);
				send_append(lo, up, 1 + rand_upto(7));
			end else begin
				send_item(FUNC_APPEND, $urandom, $urandom, '0, $urandom);
			end
		end
		4: begin
			up = lim_hi + rand_upto(S32_MAX - lim_hi);
			lo = up - rand_upto(up - S32_MIN);
			send_append(lo, up, 1 + rand_upto(7));
		end
		5: begin
			if (built_n > 0) begin
				lo = built_tail - rand_upto(built_tail - built_lo[0]);
				up = lo + rand_upto(20);
				if (up > S32_MAX) up = S32_MAX;
				send_append(lo, up, 1);
			end else begin
				send_query(pick_query());
			end
		end
		6: send_item(FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
		default: send_clear();
		endcase
	endtask

	task automatic run_session();
		int n, nq;
		case ($urandom_range(9))
		0, 1, 2, 3, 4, 5, 6: n = 1 + $urandom_range(7);
		7, 8: n = 9 + $urandom_range(21);
		default: n = 60 + $urandom_range(6);
		endcase
		builds++;
		send_clear();
		repeat (n) begin
			if ($urandom_range(99) < 15) send_noise();
			else build_append();
			if ($urandom_range(3) == 0) send_query(pick_query());
		end
		nq = n + $urandom_range(n + 4);
		if (nq > 40) nq = 40;
		repeat (nq) begin
			if ($urandom_range(99) < 85) send_query(pick_query());
			else send_noise();
		end
	endtask

	initial begin
		int base;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_CLEAR;
		req_ch.entry_lower = '0;
		req_ch.entry_upper = '0;
		req_ch.entry_step = '0;
		req_ch.query_value = '0;
		rsp_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of both limits
		apb_access(1'b0, REG_LOW_LIMIT, '0);
		apb_access(1'b0, REG_HIGH_LIMIT, '0);
		psel <= 1'b0;
		penable <= 1'b0;

		// empty table, idle selector, every append check but full in priority order, then queries
		send_query(0);
		send_item(FUNC_NONE, '1, '1, '1, '1);
		send_append(5, 10, 0);
		send_append(10, 5, -5);
		send_append(10, 5, 1);
		send_append(-1, 5, 1);
		send_append(0, S32_MAX, 1);
		send_append(0, 100, 7);
		send_append(98, 200, 1);
		send_append(99, 99, 1);
		send_append(200, S32_MAX - 1, S32_MAX);
		send_query(0);
		send_query(8);
		send_query(99);
		send_query(100);
		send_query(200);
		send_query(201);
		send_query(-1);
		send_query(S32_MAX - 1);
		send_clear();
		send_query(0);

		// widest limits, sub-ranges at the signed extremes
		set_limits(S32_MIN, S32_MAX);
		send_append(S32_MIN, S32_MIN + 10, 3);
		send_append(-1, S32_MAX - 1, 64'sh4000_0000);
		send_query(S32_MIN);
		send_query(S32_MIN + 9);
		send_query(64'sh3FFF_FFFF);
		send_query(S32_MAX);

		base = items_sent;
		while (items_sent - base < 1700) begin
			if (builds == 0 || $urandom_range(3) == 0) pick_limits();
			calm = (items_sent - base >= 700) && (items_sent - base < 1000);
			run_session();
		end
		calm = 1'b0;

		settle();
		repeat (60) @(posedge clk);
		$display("covered %0d items in %0d table builds under %0d limit settings",
			items_sent, builds, settings);
		$display("%0d result beats compared", beats);
		if (fails == 0)
			$display("PASS strided_range_set_membership");
		else
			$display("FAIL strided_range_set_membership");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results still owed", owed);
		$display("FAIL strided_range_set_membership");
		$finish;
	end

endmodule

>>> sim.f
design/srsm_pkg.sv
design/srsm_ifs.sv
design/srsm_rem.sv
design/srsm_table.sv
design/strided_range_set_membership.sv
dv/srsm_result_check.sv
dv/testbench.sv
